>>> design/wmrs_pkg.sv
package wmrs_pkg;

   localparam int NUM_WINDOWS        = 16;
   localparam int WINDOWS_PER_MODULE = 8;
   localparam int NUM_MODULES        = 2;
   localparam int MAX_RESULTS        = 16;

   localparam int WIN_W    = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
   localparam int MOD_W    = (NUM_MODULES > 1) ? $clog2(NUM_MODULES) : 1;
   localparam int EMIT_W   = $clog2(MAX_RESULTS + 1);
   localparam int RUN_W    = 20;
   localparam int PAUSE_W  = 16;
   localparam int TIME_W   = 16;
   localparam int MASK_W   = 16;
   localparam int WORD_W   = 16;
   localparam int WIDX_W   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_TIME   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE_TIME = 1'b1;

   localparam logic [RUN_W-1:0]   RUN_TIME_RESET   = 20'd60000;
   localparam logic [PAUSE_W-1:0] PAUSE_TIME_RESET = 16'd1000;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ACTION = 1'b1;

   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_STOP = 2'd2,
      DIR_NONE = 2'd3
   } dir_type;

   typedef enum logic {
      CMD_TICK   = 1'b0,
      CMD_ACTION = 1'b1
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [TIME_W-1:0]   elapsed;
      logic [MASK_W-1:0]   mask;
      dir_type             dir;
   } cmd_type;

   typedef struct packed {
      logic [RUN_W-1:0]   run_time;
      logic [PAUSE_W-1:0] pause_time;
   } cfg_type;

   typedef struct packed {
      logic [WIDX_W-1:0] window_index;
      dir_type           relay_direction;
      logic              module_index;
      logic [WORD_W-1:0] module_relays;
      logic              last_of_tick;
   } result_type;

   // (up, down) relay bits of each window slot within a module word
   localparam logic [WORD_W-1:0] RELAY_UP [8] = '{
      16'h0080, 16'h0020, 16'h0008, 16'h0002,
      16'h0100, 16'h0400, 16'h1000, 16'h4000
   };
   localparam logic [WORD_W-1:0] RELAY_DN [8] = '{
      16'h0040, 16'h0010, 16'h0004, 16'h0001,
      16'h0200, 16'h0800, 16'h2000, 16'h8000
   };

endpackage

>>> design/wmrs_ifs.sv
interface wmrs_req_if
   import wmrs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [TIME_W-1:0] elapsed_ms;
   logic [MASK_W-1:0] window_mask;
   logic [1:0]        direction;
   logic              force_stop;

   modport source (output valid, operation, elapsed_ms, window_mask, direction, force_stop,
                   input ready);
   modport sink   (input valid, operation, elapsed_ms, window_mask, direction, force_stop,
                   output ready);
endinterface

interface wmrs_rsp_if
   import wmrs_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [WIDX_W-1:0] window_index;
   logic [1:0]        relay_direction;
   logic              module_index;
   logic [WORD_W-1:0] module_relays;
   logic              last_of_tick;

   modport source (output valid, window_index, relay_direction, module_index, module_relays,
                   last_of_tick, input ready);
   modport sink   (input valid, window_index, relay_direction, module_index, module_relays,
                   last_of_tick, output ready);
endinterface

>>> design/wmrs_front.sv
module wmrs_front
   import wmrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   wmrs_req_if.sink   req,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd
);

   logic    out_valid_ff, out_valid_in;
   cmd_type out_ff, out_in;
   cmd_type classified;
   logic    keep;

   // fold force_stop into the direction, drop actions that ask for nothing
   always_comb begin
      classified.elapsed = req.elapsed_ms;
      classified.mask    = req.window_mask;
      if (req.operation == OP_ACTION) begin
         classified.kind = CMD_ACTION;
         classified.dir  = req.force_stop ? DIR_STOP : dir_type'(req.direction);
      end else begin
         classified.kind = CMD_TICK;
         classified.dir  = DIR_NONE;
      end
      keep = !(classified.kind == CMD_ACTION && classified.dir == DIR_NONE);
   end

   assign req.ready = !out_valid_ff || cmd_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !cmd_ready;
      out_in       = out_ff;
      if (req.valid && req.ready && keep) begin
         out_valid_in = 1'b1;
         out_in       = classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign cmd_valid = out_valid_ff;
   assign cmd       = out_ff;

endmodule

>>> design/wmrs_queue.sv
module wmrs_queue
   import wmrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/wmrs_back.sv
module wmrs_back
   import wmrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   wmrs_rsp_if.source rsp
);

   state_type          state_ff, state_in;
   logic [WIN_W-1:0]   walk_ff, walk_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [EMIT_W-1:0]  emit_cnt_ff, emit_cnt_in;

   logic [RUN_W-1:0]   run_ff     [NUM_WINDOWS];
   logic [RUN_W-1:0]   run_in     [NUM_WINDOWS];
   logic [PAUSE_W-1:0] pause_ff   [NUM_WINDOWS];
   logic [PAUSE_W-1:0] pause_in   [NUM_WINDOWS];
   dir_type            req_dir_ff [NUM_WINDOWS];
   dir_type            req_dir_in [NUM_WINDOWS];
   dir_type            drv_ff     [NUM_WINDOWS];
   dir_type            drv_in     [NUM_WINDOWS];
   logic [WORD_W-1:0]  relay_ff   [NUM_MODULES];
   logic [WORD_W-1:0]  relay_in   [NUM_MODULES];

   logic               hold_valid_ff, hold_valid_in;
   result_type         hold_ff, hold_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   // one window step
   logic [PAUSE_W-1:0] cur_pause, nx_pause;
   logic [RUN_W-1:0]   cur_run, nx_run;
   dir_type            cur_drv, nx_req, cmd_dir;
   logic               changed, in_module, produce, out_free, stall, last_window;
   int unsigned        mod_num;
   logic [MOD_W-1:0]   mod_idx;
   logic [2:0]         slot;
   logic [WORD_W-1:0]  cur_word, nx_word, up_bit, dn_bit;
   result_type         step_res;

   always_comb begin
      cur_pause = pause_ff[walk_ff];
      cur_run   = run_ff[walk_ff];
      cur_drv   = drv_ff[walk_ff];
      nx_pause  = cur_pause;
      nx_run    = cur_run;
      nx_req    = req_dir_ff[walk_ff];
      cmd_dir   = DIR_STOP;
      changed   = 1'b0;
      if (cur_pause > elapsed_ff) begin
         nx_pause = cur_pause - elapsed_ff;
      end else begin
         nx_pause = '0;
         if (cur_run != '0) begin
            if (cur_run > RUN_W'(elapsed_ff)) begin
               nx_run = cur_run - RUN_W'(elapsed_ff);
            end else begin
               nx_run = '0;
               nx_req = DIR_STOP;
            end
         end
         if (cur_drv != nx_req) begin
            changed = 1'b1;
            if (cur_drv == DIR_STOP) begin
               cmd_dir = nx_req;
            end else begin
               // reversal: stop first and start the dead time
               cmd_dir  = DIR_STOP;
               nx_pause = cfg.pause_time;
            end
         end
      end
   end

   always_comb begin
      mod_num   = int'(walk_ff) / WINDOWS_PER_MODULE;
      mod_idx   = MOD_W'(mod_num);
      slot      = 3'(int'(walk_ff) % WINDOWS_PER_MODULE);
      in_module = (mod_num < NUM_MODULES);
      up_bit    = RELAY_UP[slot];
      dn_bit    = RELAY_DN[slot];
      cur_word  = relay_ff[mod_idx];
      unique case (cmd_dir)
         DIR_UP:   nx_word = (cur_word | up_bit) & ~dn_bit;
         DIR_DOWN: nx_word = (cur_word | dn_bit) & ~up_bit;
         default:  nx_word = cur_word & ~(up_bit | dn_bit);
      endcase
      step_res.window_index    = WIDX_W'(walk_ff);
      step_res.relay_direction = cmd_dir;
      step_res.module_index    = 1'(mod_num);
      step_res.module_relays   = nx_word;
      step_res.last_of_tick    = 1'b0;
   end

   assign out_free    = !out_valid_ff || rsp.ready;
   assign produce     = changed && in_module && (emit_cnt_ff < EMIT_W'(MAX_RESULTS));
   assign stall       = produce && hold_valid_ff && !out_free;
   assign last_window = (walk_ff == WIN_W'(NUM_WINDOWS - 1));

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      elapsed_in    = elapsed_ff;
      emit_cnt_in   = emit_cnt_ff;
      run_in        = run_ff;
      pause_in      = pause_ff;
      req_dir_in    = req_dir_ff;
      drv_in        = drv_ff;
      relay_in      = relay_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_in        = out_ff;
      cmd_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               if (cmd.kind == CMD_ACTION) begin
                  for (int i = 0; i < NUM_WINDOWS && i < MASK_W; i++) begin
                     if (cmd.mask[i]) begin
                        req_dir_in[i] = cmd.dir;
                        run_in[i]     = cfg.run_time;
                     end
                  end
               end else begin
                  elapsed_in  = cmd.elapsed;
                  walk_in     = '0;
                  emit_cnt_in = '0;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!stall) begin
               pause_in[walk_ff]   = nx_pause;
               run_in[walk_ff]     = nx_run;
               req_dir_in[walk_ff] = nx_req;
               if (changed) begin
                  drv_in[walk_ff] = cmd_dir;
                  if (in_module) begin
                     relay_in[mod_idx] = nx_word;
                  end
               end
               if (produce) begin
                  // push the held result out, keep the new one until we know it is not last
                  if (hold_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_in       = hold_ff;
                  end
                  hold_valid_in = 1'b1;
                  hold_in       = step_res;
                  emit_cnt_in   = emit_cnt_ff + 1'b1;
               end
               if (last_window) begin
                  state_in = ST_FINISH;
               end else begin
                  walk_in = walk_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in        = 1'b1;
               out_in              = hold_ff;
               out_in.last_of_tick = 1'b1;
               hold_valid_in       = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_ff       <= '0;
         emit_cnt_ff   <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_WINDOWS; i++) begin
            run_ff[i]     <= '0;
            pause_ff[i]   <= '0;
            req_dir_ff[i] <= DIR_STOP;
            drv_ff[i]     <= DIR_STOP;
         end
         for (int m = 0; m < NUM_MODULES; m++) begin
            relay_ff[m] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         emit_cnt_ff   <= emit_cnt_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         run_ff        <= run_in;
         pause_ff      <= pause_in;
         req_dir_ff    <= req_dir_in;
         drv_ff        <= drv_in;
         relay_ff      <= relay_in;
      end
      elapsed_ff <= elapsed_in;
      hold_ff    <= hold_in;
      out_ff     <= out_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.window_index    = out_ff.window_index;
   assign rsp.relay_direction = out_ff.relay_direction;
   assign rsp.module_index    = out_ff.module_index;
   assign rsp.module_relays   = out_ff.module_relays;
   assign rsp.last_of_tick    = out_ff.last_of_tick;

   a_hold_empty_when_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("held result left over outside a tick");

   a_emit_bounded: assert property (@(posedge clock) disable iff (reset)
      emit_cnt_ff <= EMIT_W'(MAX_RESULTS))
      else $error("too many results in one tick");

   a_stall_holds_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK && stall |=> state_ff == ST_WALK && walk_ff == $past(walk_ff))
      else $error("window walk advanced while the output was blocked");

   a_no_none_drive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.relay_direction != DIR_NONE)
      else $error("relay commanded with direction none");

endmodule

>>> design/window_motor_relay_sequencer.sv
// Window motor relay sequencer: drives the up/down relay pairs of 16 windows spread over two
// 16-bit relay modules. Action beats (operation 1) set the requested direction of every window
// in window_mask and reload its run timer; they are applied while the sequencer is idle and produce
// nothing. A direction of none without force_stop is dropped at the input. Tick beats
// (operation 0) count each window's pause and run timers down by elapsed_ms and move the driven
// direction toward the request; a reversal commands stop and starts the dead time first. A tick
// walks the windows one per cycle unless the result side stalls: the sequencer takes the beat
// while idle, walks all 16 windows, then closes the tick before taking the next beat. Every
// relay change yields one result beat carrying the module's full relay word; last_of_tick marks
// the final beat of a tick, and a tick that changes nothing gives no beat. A classify register
// and a four-entry command queue sit in front of the sequencer, so input beats keep being taken
// while a tick is walked, as long as the queue has room.
// Configuration (index 0 run time, index 1 pause time) is written through the csr_ port, applies
// to the next beats; the user must write it only while the block is idle (not enforced).
module window_motor_relay_sequencer
   import wmrs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   wmrs_req_if.sink               req,
   wmrs_rsp_if.source             rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic [RUN_W-1:0]   run_time_ff, run_time_in;
   logic [PAUSE_W-1:0] pause_time_ff, pause_time_in;
   cfg_type            cfg;

   // front register to queue, queue to sequencer
   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   always_comb begin
      run_time_in   = run_time_ff;
      pause_time_in = pause_time_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RUN_TIME:   run_time_in   = RUN_W'(csr_write_data);
            CSR_PAUSE_TIME: pause_time_in = PAUSE_W'(csr_write_data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_time_ff   <= RUN_TIME_RESET;
         pause_time_ff <= PAUSE_TIME_RESET;
      end else begin
         run_time_ff   <= run_time_in;
         pause_time_ff <= pause_time_in;
      end
   end

   assign cfg.run_time   = run_time_ff;
   assign cfg.pause_time = pause_time_ff;

   // classify input beats
   wmrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   // decouple intake from the window walk
   wmrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_cmd)
   );

   // apply actions, walk ticks, emit relay updates
   wmrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd       (qb_cmd),
      .rsp       (rsp)
   );

endmodule
